// ===== design/tlsu_pkg.sv =====
// tlsu_pkg: shared types, codes and helpers of the thumb load/store unit
package tlsu_pkg;

	// register list width of LDMIA/STMIA, fixed by the encoding
	localparam int NUM_LIST_REGS = 8;

	// commands
	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_SET  = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_REG   = 2'd2;
	localparam logic [1:0] KIND_FAULT = 2'd3;

	// thumb major opcodes, instruction bits 15:11
	localparam logic [4:0] OP_LDR_PC  = 5'h09;
	localparam logic [4:0] OP_STR_IMM = 5'h0C;
	localparam logic [4:0] OP_LDR_IMM = 5'h0D;
	localparam logic [4:0] OP_STRH    = 5'h10;
	localparam logic [4:0] OP_STMIA   = 5'h18;
	localparam logic [4:0] OP_LDMIA   = 5'h19;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] instruction;
		logic [31:0] pc;
		logic [2:0]  reg_index;
		logic [31:0] data;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [31:0] value;
		logic        is_word;
		logic        last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MULTI,
		ST_WB
	} state_t;

	// index of the lowest set bit of a register list
	function automatic logic [2:0] lowest_idx(input logic [NUM_LIST_REGS-1:0] list);
		logic [2:0] idx;
		idx = '0;
		for (int i = NUM_LIST_REGS - 1; i >= 0; i--) begin
			if (list[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	// number of registers in a list
	function automatic logic [3:0] list_count(input logic [NUM_LIST_REGS-1:0] list);
		logic [3:0] cnt;
		cnt = '0;
		for (int i = 0; i < NUM_LIST_REGS; i++) begin
			cnt = cnt + {3'b000, list[i]};
		end
		return cnt;
	endfunction

endpackage

// ===== design/tlsu_regfile.sv =====
// tlsu_regfile: eight low registers, one write port, two registered read ports
module tlsu_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [2:0]  ra_addr,
	input  logic [2:0]  rb_addr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data
);
	import tlsu_pkg::*;

	logic [31:0] mem [8];
	logic [7:0]  vld_q;
	logic [31:0] ra_q;
	logic [31:0] rb_q;
	logic        ra_vld_q;
	logic        rb_vld_q;

	// storage and read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_q <= mem[ra_addr];
		rb_q <= mem[rb_addr];
	end

	// written flags, an unwritten register reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			ra_vld_q <= 1'b0;
			rb_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			ra_vld_q <= vld_q[ra_addr];
			rb_vld_q <= vld_q[rb_addr];
		end
	end

	assign ra_data = ra_vld_q ? ra_q : '0;
	assign rb_data = rb_vld_q ? rb_q : '0;

endmodule

// ===== design/thumb_load_store_unit.sv =====
// thumb_load_store_unit: thumb LDR/STR/STRH/LDMIA/STMIA sequencer over the low registers
//
// Usage:
//   An input transaction (req) is taken at a clock edge with start high and busy low.
//   Commands: execute an instruction, return load data, set a register, read a register.
//   Results appear on rsp for one cycle each, flagged by rsp_valid; last marks the
//   final result of a transaction. The receiver cannot stall; results are never held.
// Sequence:
//   set register, load data, PC-relative LDR and any fault: handled in idle, result (if any)
//   in the cycle after acceptance.
//   read register, LDR/STR/STRH immediate: pass through EXEC for the registered file read.
//   LDMIA/STMIA with n listed registers: EXEC, then n requests, one per cycle while the
//   list is walked through read port B of the register file.
//   load data that completes an LDMIA with base writeback: then WB for the writeback write.
// Reset:
//   arst_n clears all registers to zero (via written flags), the pending load mask and
//   the writeback, and returns the sequencer to idle. No clearing pass is needed.
// Loads leave their registers pending; returned words fill them in ascending order and
// an execute transaction while any are pending gets a fault.
module thumb_load_store_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tlsu_pkg::req_t req,
	output logic           rsp_valid,
	output tlsu_pkg::rsp_t rsp
);
	import tlsu_pkg::*;

	state_t      state_q, state_d;
	req_t        req_q, req_d;
	logic [7:0]  mask_q, mask_d;
	logic        wbp_q, wbp_d;
	logic [2:0]  wbreg_q, wbreg_d;
	logic [31:0] wbval_q, wbval_d;
	logic [7:0]  list_q, list_d;
	logic [31:0] addr_q, addr_d;
	rsp_t        rsp_q, rsp_d;
	logic        rsp_valid_q, rsp_valid_d;

	logic        we;
	logic [2:0]  waddr;
	logic [31:0] wdata;
	logic [2:0]  ra_addr;
	logic [2:0]  rb_addr;
	logic [31:0] rd_a;
	logic [31:0] rd_b;

	logic [4:0]  in_op;
	logic [4:0]  op_q;
	logic [7:0]  list_rest;
	logic [31:0] sum;
	logic [7:0]  mask_left;

	tlsu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.ra_addr (ra_addr),
		.rb_addr (rb_addr),
		.ra_data (rd_a),
		.rb_data (rd_b)
	);

	assign in_op     = req.instruction[15:11];
	assign op_q      = req_q.instruction[15:11];
	assign list_rest = list_q & (list_q - 8'd1);
	assign mask_left = mask_q & (mask_q - 8'd1);

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			wbp_q       <= 1'b0;
			wbreg_q     <= '0;
			wbval_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mask_q      <= mask_d;
			wbp_q       <= wbp_d;
			wbreg_q     <= wbreg_d;
			wbval_q     <= wbval_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// transaction payload, list walker and result register
	always_ff @(posedge clk) begin
		req_q  <= req_d;
		list_q <= list_d;
		addr_q <= addr_d;
		rsp_q  <= rsp_d;
	end

	// sequencer: next state, register file access and results
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		mask_d      = mask_q;
		wbp_d       = wbp_q;
		wbreg_d     = wbreg_q;
		wbval_d     = wbval_q;
		list_d      = list_q;
		addr_d      = addr_q;
		rsp_d       = '0;
		rsp_valid_d = 1'b0;
		we          = 1'b0;
		waddr       = '0;
		wdata       = '0;
		ra_addr     = '0;
		rb_addr     = '0;
		sum         = '0;

		case (state_q)
			ST_IDLE: begin
				// address the register file from the incoming transaction
				if (req.cmd == CMD_READ) begin
					ra_addr = req.reg_index;
				end else if (in_op == OP_STMIA || in_op == OP_LDMIA) begin
					ra_addr = req.instruction[10:8];
				end else begin
					ra_addr = req.instruction[5:3];
				end
				rb_addr = req.instruction[2:0];
				if (start) begin
					req_d = req;
					case (req.cmd)
						CMD_SET: begin
							we    = 1'b1;
							waddr = req.reg_index;
							wdata = req.data;
						end
						CMD_LOAD: begin
							if (mask_q == '0) begin
								rsp_d.kind  = KIND_FAULT;
								rsp_d.last  = 1'b1;
								rsp_valid_d = 1'b1;
							end else begin
								// fill the lowest pending register
								we     = 1'b1;
								waddr  = lowest_idx(mask_q);
								wdata  = req.data;
								mask_d = mask_left;
								if (mask_left == '0 && wbp_q) begin
									state_d = ST_WB;
								end
							end
						end
						CMD_READ: begin
							state_d = ST_EXEC;
						end
						default: begin
							if (mask_q != '0) begin
								rsp_d.kind  = KIND_FAULT;
								rsp_d.last  = 1'b1;
								rsp_valid_d = 1'b1;
							end else begin
								case (in_op)
									OP_LDR_PC: begin
										rsp_d.kind    = KIND_READ;
										rsp_d.address = {req.pc[31:2], 2'b00}
											+ {22'd0, req.instruction[7:0], 2'b00};
										rsp_d.is_word = 1'b1;
										rsp_d.last    = 1'b1;
										rsp_valid_d   = 1'b1;
										mask_d        = 8'd1 << req.instruction[10:8];
										wbp_d         = 1'b0;
									end
									OP_LDR_IMM, OP_STR_IMM, OP_STRH: begin
										state_d = ST_EXEC;
									end
									OP_STMIA, OP_LDMIA: begin
										if (req.instruction[7:0] == '0) begin
											rsp_d.kind  = KIND_FAULT;
											rsp_d.last  = 1'b1;
											rsp_valid_d = 1'b1;
										end else begin
											state_d = ST_EXEC;
										end
									end
									default: begin
										rsp_d.kind  = KIND_FAULT;
										rsp_d.last  = 1'b1;
										rsp_valid_d = 1'b1;
									end
								endcase
							end
						end
					endcase
				end
			end

			ST_EXEC: begin
				// register file data for the latched transaction is valid here
				state_d = ST_IDLE;
				if (req_q.cmd == CMD_READ) begin
					rsp_d.kind  = KIND_REG;
					rsp_d.value = rd_a;
					rsp_d.last  = 1'b1;
					rsp_valid_d = 1'b1;
				end else begin
					case (op_q)
						OP_LDR_IMM: begin
							sum           = rd_a + {25'd0, req_q.instruction[10:6], 2'b00};
							rsp_d.kind    = KIND_READ;
							rsp_d.address = {sum[31:2], 2'b00};
							rsp_d.is_word = 1'b1;
							rsp_d.last    = 1'b1;
							rsp_valid_d   = 1'b1;
							mask_d        = 8'd1 << req_q.instruction[2:0];
							wbp_d         = 1'b0;
						end
						OP_STR_IMM: begin
							sum           = rd_a + {25'd0, req_q.instruction[10:6], 2'b00};
							rsp_d.kind    = KIND_WRITE;
							rsp_d.address = {sum[31:2], 2'b00};
							rsp_d.value   = rd_b;
							rsp_d.is_word = 1'b1;
							rsp_d.last    = 1'b1;
							rsp_valid_d   = 1'b1;
						end
						OP_STRH: begin
							sum           = rd_a + {26'd0, req_q.instruction[10:6], 1'b0};
							rsp_d.kind    = KIND_WRITE;
							rsp_d.address = {sum[31:1], 1'b0};
							rsp_d.value   = {16'd0, rd_b[15:0]};
							rsp_d.last    = 1'b1;
							rsp_valid_d   = 1'b1;
						end
						default: begin
							// start the list walk, fetch the first listed register
							addr_d  = rd_a;
							list_d  = req_q.instruction[7:0];
							wbreg_d = req_q.instruction[10:8];
							wbval_d = rd_a
								+ {26'd0, list_count(req_q.instruction[7:0]), 2'b00};
							rb_addr = lowest_idx(req_q.instruction[7:0]);
							state_d = ST_MULTI;
						end
					endcase
				end
			end

			ST_MULTI: begin
				// one request per listed register, next register fetched alongside
				rsp_d.kind    = (op_q == OP_STMIA) ? KIND_WRITE : KIND_READ;
				rsp_d.address = {addr_q[31:2], 2'b00};
				rsp_d.value   = (op_q == OP_STMIA) ? rd_b : '0;
				rsp_d.is_word = 1'b1;
				rsp_d.last    = (list_rest == '0);
				rsp_valid_d   = 1'b1;
				addr_d        = addr_q + 32'd4;
				list_d        = list_rest;
				rb_addr       = lowest_idx(list_rest);
				if (list_rest == '0) begin
					state_d = ST_IDLE;
					if (op_q == OP_STMIA) begin
						we    = 1'b1;
						waddr = wbreg_q;
						wdata = wbval_q;
					end else begin
						mask_d = req_q.instruction[7:0];
						wbp_d  = 1'b1;
					end
				end
			end

			ST_WB: begin
				// base writeback after the last returned word
				we      = 1'b1;
				waddr   = wbreg_q;
				wdata   = wbval_q;
				wbp_d   = 1'b0;
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a drained load mask with writeback outstanding only exists in the writeback cycle
	a_wb_only_in_wb_state: assert property (@(posedge clk) disable iff (!arst_n)
		(wbp_q && mask_q == '0) |-> (state_q == ST_WB))
		else $error("writeback pending outside writeback state");

	// every list walk cycle produces a request
	a_multi_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULTI) |=> (rsp_valid && rsp.kind != KIND_FAULT
			&& rsp.kind != KIND_REG))
		else $error("list walk cycle without a memory request");

	// execute while loads are pending gives a fault next cycle
	a_pending_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_EXEC && mask_q != '0)
			|=> (rsp_valid && rsp.kind == KIND_FAULT && rsp.last && !busy))
		else $error("execute with pending loads did not fault");

endmodule
